// ----- rtl/jpd_pkg.sv -----
// Shared types and constants for the joystick packet deframer.
`timescale 1ns / 1ps

package jpd_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] SUM_GOOD    = 8'hFF;
  localparam logic [7:0] OFFSET_FLIP = 8'h80;

  // Positions inside a packet: six data bytes, then the checksum.
  localparam int         DATA_LEN  = 6;
  localparam logic [2:0] CHECK_POS = 3'd6;

  localparam int JPD_QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    CMD_DATA = 1'b0,
    CMD_EMIT = 1'b1
  } jpd_cmd_kind_t;

  // One entry of the queue between the front and the back.
  typedef struct packed {
    jpd_cmd_kind_t kind;
    logic [2:0]    pos;
    logic [7:0]    data;
  } jpd_cmd_t;

endpackage

// ----- rtl/jpd_in_if.sv -----
// Input byte channel of the joystick packet deframer.
`timescale 1ns / 1ps

interface jpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/jpd_out_if.sv -----
// Result channel of the joystick packet deframer.
`timescale 1ns / 1ps

interface jpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  left_v;
  logic signed [7:0]  left_h;
  logic signed [7:0]  right_v;
  logic signed [7:0]  right_h;
  logic        [15:0] pan_word;
  logic        [15:0] tilt_word;
  logic        [7:0]  button_bits;
  logic        [7:0]  ext_byte;

  modport source (output valid, output left_v, output left_h, output right_v,
                  output right_h, output pan_word, output tilt_word,
                  output button_bits, output ext_byte, input ready);
  modport sink (input valid, input left_v, input left_h, input right_v,
                input right_h, input pan_word, input tilt_word,
                input button_bits, input ext_byte, output ready);
endinterface

// ----- rtl/jpd_front.sv -----
// Front end: header hunt, byte position, running checksum and command issue.
`timescale 1ns / 1ps

module jpd_front import jpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  jpd_in_if.sink    in_ch,
  input  logic      q_full,
  output logic      q_push,
  output jpd_cmd_t  q_cmd
);

  logic       hunting_r, hunting_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sum_add;
  logic       accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign sum_add     = sum_r + in_ch.rx_byte;

  always_comb begin
    hunting_nxt  = hunting_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    q_push       = 1'b0;
    q_cmd.kind   = CMD_DATA;
    q_cmd.pos    = pos_r;
    q_cmd.data   = in_ch.rx_byte;
    if (accept) begin
      if (hunting_r) begin
        if (in_ch.rx_byte == HDR_BYTE) begin
          hunting_nxt = 1'b0;
          pos_nxt     = '0;
          sum_nxt     = '0;
        end
      end else if (!(pos_r == '0 && in_ch.rx_byte == HDR_BYTE)) begin
        // A repeated header in the first data slot is skipped above.
        sum_nxt = sum_add;
        if (pos_r == CHECK_POS) begin
          hunting_nxt = 1'b1;
          pos_nxt     = '0;
          q_cmd.kind  = CMD_EMIT;
          q_push      = (sum_add == SUM_GOOD);
        end else begin
          pos_nxt = pos_r + 3'd1;
          q_push  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hunting_r <= 1'b1;
      pos_r     <= '0;
      sum_r     <= '0;
    end else begin
      hunting_r <= hunting_nxt;
      pos_r     <= pos_nxt;
      sum_r     <= sum_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CHECK_POS)
    else $error("byte position out of range");

  a_emit_at_check: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_cmd.kind == CMD_EMIT) |=> hunting_r && pos_r == '0)
    else $error("emit issued without returning to header hunt");

endmodule

// ----- rtl/jpd_fifo.sv -----
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module jpd_fifo import jpd_pkg::*; #(
  parameter int Depth = JPD_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  jpd_cmd_t push_cmd,
  output logic     full,
  output logic     pop_valid,
  output jpd_cmd_t pop_cmd,
  input  logic     pop
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jpd_cmd_t            mem_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;

  assign full      = (count_r == CntW'(Depth));
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("queue read while empty");

endmodule

// ----- rtl/jpd_back.sv -----
// Back end: packet byte store, stick mapping and result register.
`timescale 1ns / 1ps

module jpd_back import jpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      cmd_valid,
  input  jpd_cmd_t  cmd,
  output logic      cmd_pop,
  jpd_out_if.source out_ch
);

  logic              south_paw_r;
  logic [7:0]        pkt_r [DATA_LEN];
  logic              out_valid_r, out_valid_nxt;
  logic signed [7:0] left_v_r, left_h_r, right_v_r, right_h_r;
  logic [15:0]       pan_r, tilt_r;
  logic [7:0]        button_r, ext_r;
  logic              do_data, do_emit;
  logic [7:0]        ctr0, ctr1, ctr2, ctr3;

  // A data byte never waits; an emit waits for the result register to free up.
  always_comb begin
    do_data = 1'b0;
    do_emit = 1'b0;
    if (cmd_valid) begin
      unique case (cmd.kind)
        CMD_DATA: do_data = 1'b1;
        CMD_EMIT: do_emit = !out_valid_r || out_ch.ready;
        default:  do_data = 1'b0;
      endcase
    end
  end

  assign cmd_pop = do_data || do_emit;

  assign ctr0 = pkt_r[0] ^ OFFSET_FLIP;
  assign ctr1 = pkt_r[1] ^ OFFSET_FLIP;
  assign ctr2 = pkt_r[2] ^ OFFSET_FLIP;
  assign ctr3 = pkt_r[3] ^ OFFSET_FLIP;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      south_paw_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        south_paw_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_data) begin
      pkt_r[cmd.pos] <= cmd.data;
    end
    if (do_emit) begin
      left_v_r  <= signed'(south_paw_r ? ctr2 : ctr0);
      left_h_r  <= signed'(south_paw_r ? ctr3 : ctr1);
      right_v_r <= signed'(south_paw_r ? ctr0 : ctr2);
      right_h_r <= signed'(south_paw_r ? ctr1 : ctr3);
      pan_r     <= {pkt_r[0], pkt_r[1]};
      tilt_r    <= {pkt_r[2], pkt_r[3]};
      button_r  <= pkt_r[4];
      ext_r     <= pkt_r[5];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_v      = left_v_r;
  assign out_ch.left_h      = left_h_r;
  assign out_ch.right_v     = right_v_r;
  assign out_ch.right_h     = right_h_r;
  assign out_ch.pan_word    = pan_r;
  assign out_ch.tilt_word   = tilt_r;
  assign out_ch.button_bits = button_r;
  assign out_ch.ext_byte    = ext_r;

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    do_emit |=> out_valid_r)
    else $error("emit did not load the result register");

  a_data_pos: assert property (@(posedge clk) disable iff (!rst_n)
    do_data |-> cmd.pos < CHECK_POS)
    else $error("data byte position beyond the packet store");

endmodule

// ----- rtl/joystick_packet_deframer_core.sv -----
// Top level of the joystick packet deframer.
`timescale 1ns / 1ps

// Takes one received serial byte per transfer on in_ch and gives one result on
// out_ch for each packet that passes its checksum: a 0xFF header (repeats are
// skipped), six data bytes and a checksum byte whose 8-bit sum with the data
// is 0xFF. Bad packets are dropped without a trace. The block takes one byte
// per clock cycle while the queue is not full; the front classifies each
// accepted byte combinationally and hands data bytes and good-packet marks
// through a short queue to the back, which stores the bytes and loads the
// result register when a mark leaves the queue. in_ch.ready drops only when the
// queue fills, which happens only while a result waits on out_ch. cfg_we with
// cfg_wdata sets the south-paw swap, which applies to the next result loaded.
module joystick_packet_deframer_core import jpd_pkg::*; #(
  parameter int QueueDepth = JPD_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  jpd_in_if.sink    in_ch,
  jpd_out_if.source out_ch
);

  logic     q_push, q_full, q_pop_valid, q_pop;
  jpd_cmd_t q_push_cmd, q_pop_cmd;

  jpd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  jpd_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .full      (q_full),
    .pop_valid (q_pop_valid),
    .pop_cmd   (q_pop_cmd),
    .pop       (q_pop)
  );

  jpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (q_pop_valid),
    .cmd       (q_pop_cmd),
    .cmd_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule
